// File: sv/hcc_pkg.sv
// Shared types, constants and bit-level helpers for the Hamming codec.
package hcc_pkg;

    localparam int CODE_W = 31;
    localparam int SYN_W  = 5;
    localparam int LEN_W  = 5;
    localparam int DBITS_W = 5;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register map
    localparam logic REG_DATA_BITS = 1'b0;
    localparam logic [DBITS_W-1:0] DATA_BITS_RESET = 5'd4;

    // Operation codes
    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_CHECK  = 1'b1;

    typedef struct packed {
        logic              func;
        logic [CODE_W-1:0] payload;
    } hcc_in_t;

    typedef struct packed {
        logic [CODE_W-1:0] codeword;
        logic [SYN_W-1:0]  syndrome;
        logic              error_found;
        logic              uncorrectable;
    } hcc_out_t;

    // Work carried between pipeline stages
    typedef struct packed {
        logic              func;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] word;
        logic [SYN_W-1:0]  syn;
    } hcc_stage_t;

    // Data bit k lands on the k-th position that is not a power of two
    function automatic logic [CODE_W-1:0] scatter_data(input logic [CODE_W-1:0] d);
        logic [CODE_W-1:0] w;
        int k;
        w = '0;
        k = 0;
        for (int p = 1; p <= CODE_W; p++)
        begin
            if ((p & (p - 1)) != 0)
            begin
                w[p-1] = d[k];
                k++;
            end
        end
        return w;
    endfunction

    // Positions 1..len kept, the rest cleared
    function automatic logic [CODE_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [CODE_W-1:0] m;
        for (int i = 0; i < CODE_W; i++)
        begin
            m[i] = (LEN_W'(i) < len);
        end
        return m;
    endfunction

    // XOR of the indices of all set positions
    function automatic logic [SYN_W-1:0] syndrome_of(input logic [CODE_W-1:0] w);
        logic [SYN_W-1:0] s;
        s = '0;
        for (int p = 1; p <= CODE_W; p++)
        begin
            if (w[p-1])
            begin
                s = s ^ SYN_W'(p);
            end
        end
        return s;
    endfunction

endpackage

// File: sv/hamming_codec_31_26.sv
// Hamming (31,26) single-error-correcting codec, top level.
//
// Input channel in_valid/in_stall/in_data carries func and payload: func
// selects encode (data bit k at bit k) or check (codeword position i at
// bit i-1). Output channel out_valid/out_stall/out_data returns the
// codeword, syndrome, error_found and uncorrectable for each transfer.
// The APB port holds data_bits at byte address 0; it sets the codeword
// length. The user writes it only while no transfer is in flight; the block itself does not enforce this.
//
// Each transfer passes through the stage 1 and stage 2 registers into the
// output register, where out_valid rises. Stage 1 scatters and masks,
// stage 2 runs the syndrome XOR tree, stage 3 inserts parity or flips the
// named bit into the output register.
// Throughput is one transfer per cycle when the receiver does not stall.
//
// Reset clears all stage valid bits and sets data_bits to 4 (length 7).
// When out_stall is high the output register holds; the stages behind it
// keep filling bubbles, and in_stall rises only once all three are full.
module hamming_codec_31_26 #(
    parameter int MAX_CODE_BITS = 31
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  hcc_pkg::hcc_in_t               in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output hcc_pkg::hcc_out_t              out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hcc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [hcc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [hcc_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import hcc_pkg::*;

    logic [LEN_W-1:0] code_len;
    logic             s1_valid;
    logic             s2_valid;
    hcc_stage_t       s1_stage;
    hcc_stage_t       s2_stage;
    logic             en1;
    logic             en2;
    logic             en3;

    // Stage loads when empty or when the stage ahead moves on
    assign en3      = !out_valid || !out_stall;
    assign en2      = !s2_valid || en3;
    assign en1      = !s1_valid || en2;
    assign in_stall = !en1;

    hcc_regs #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .code_len (code_len)
    );

    hcc_stage_in u_stage_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en1),
        .in_valid (in_valid),
        .in_data  (in_data),
        .code_len (code_len),
        .valid    (s1_valid),
        .stage    (s1_stage)
    );

    hcc_syndrome u_syndrome (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en2),
        .valid_in (s1_valid),
        .stage_in (s1_stage),
        .valid    (s2_valid),
        .stage    (s2_stage)
    );

    hcc_correct u_correct (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en3),
        .valid_in  (s2_valid),
        .stage_in  (s2_stage),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // Input backs up only when every stage is full and the output stalls
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid && s2_valid && out_valid && out_stall))
        else $error("in_stall raised with room in the pipeline");

    // error_found tracks a nonzero syndrome
    a_found_syn: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.error_found == (out_data.syndrome != '0)))
        else $error("error_found disagrees with syndrome");

    // uncorrectable is a subset of error_found
    a_bad_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.uncorrectable) |-> out_data.error_found)
        else $error("uncorrectable without error_found");

    // A stage 2 item is never dropped while the output stage is stalled
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid && !en3) |=> (s2_valid && $stable(s2_stage)))
        else $error("stage 2 item lost during stall");

endmodule

// File: sv/hcc_regs.sv
// Configuration register file and codeword length decode.
module hcc_regs #(
    parameter int MAX_CODE_BITS = 31
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hcc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [hcc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [hcc_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic [hcc_pkg::LEN_W-1:0]      code_len
);
    import hcc_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CODE_BITS);

    logic [DBITS_W-1:0] data_bits_reg;
    logic [DBITS_W-1:0] data_bits_next;
    logic               wr_en;
    logic               reg_sel;

    function automatic logic [LEN_W-1:0] code_length(input logic [DBITS_W-1:0] db);
        logic [DBITS_W-1:0] d;
        logic [LEN_W-1:0]   len;
        d = db;
        if (d == '0)
        begin
            d = 5'd1;
        end
        if (d > 5'd26)
        begin
            d = 5'd26;
        end
        if (d == 5'd1)
        begin
            len = 5'd3;
        end
        else if (d < 5'd5)
        begin
            len = d + 5'd3;
        end
        else if (d < 5'd12)
        begin
            len = d + 5'd4;
        end
        else
        begin
            len = d + 5'd5;
        end
        if (len > MAX_LEN)
        begin
            len = MAX_LEN;
        end
        return len;
    endfunction

    // Word decode: register index is the byte address over four
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        data_bits_next = data_bits_reg;
        if (wr_en && reg_sel == REG_DATA_BITS)
        begin
            data_bits_next = pwdata[DBITS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_bits_reg <= DATA_BITS_RESET;
        end
        else
        begin
            data_bits_reg <= data_bits_next;
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        if (reg_sel == REG_DATA_BITS)
        begin
            prdata = {{(APB_DATA_W-DBITS_W){1'b0}}, data_bits_reg};
        end
    end

    assign code_len = code_length(data_bits_reg);

endmodule

// File: sv/hcc_stage_in.sv
// Stage 1: data scatter for encode, length masking for both operations.
module hcc_stage_in (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  hcc_pkg::hcc_in_t           in_data,
    input  logic [hcc_pkg::LEN_W-1:0]  code_len,
    output logic                       valid,
    output hcc_pkg::hcc_stage_t        stage
);
    import hcc_pkg::*;

    logic        valid_reg;
    hcc_stage_t  stage_reg;
    hcc_stage_t  stage_next;
    logic [CODE_W-1:0] mask;

    assign mask = len_mask(code_len);

    always_comb
    begin
        stage_next.func = in_data.func;
        stage_next.len  = code_len;
        stage_next.syn  = '0;
        if (in_data.func == FUNC_ENCODE)
        begin
            stage_next.word = scatter_data(in_data.payload) & mask;
        end
        else
        begin
            stage_next.word = in_data.payload & mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign valid = valid_reg;
    assign stage = stage_reg;

endmodule

// File: sv/hcc_syndrome.sv
// Stage 2: syndrome XOR tree over the masked word.
module hcc_syndrome (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                valid_in,
    input  hcc_pkg::hcc_stage_t stage_in,
    output logic                valid,
    output hcc_pkg::hcc_stage_t stage
);
    import hcc_pkg::*;

    logic       valid_reg;
    hcc_stage_t stage_reg;
    hcc_stage_t stage_next;

    always_comb
    begin
        stage_next     = stage_in;
        stage_next.syn = syndrome_of(stage_in.word);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign valid = valid_reg;
    assign stage = stage_reg;

endmodule

// File: sv/hcc_correct.sv
// Stage 3: parity insert or single-bit correction, into the output register.
module hcc_correct (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                valid_in,
    input  hcc_pkg::hcc_stage_t stage_in,
    output logic                out_valid,
    output hcc_pkg::hcc_out_t   out_data
);
    import hcc_pkg::*;

    logic              valid_reg;
    hcc_out_t          out_reg;
    hcc_out_t          out_next;
    logic [CODE_W-1:0] parity;
    logic [CODE_W-1:0] flip;
    logic              found;
    logic              bad;

    // Parity bits land on positions 1, 2, 4, 8, 16 inside the length
    always_comb
    begin
        parity = '0;
        for (int t = 0; t < SYN_W; t++)
        begin
            if (stage_in.syn[t] && (LEN_W'(1 << t) <= stage_in.len))
            begin
                parity[(1 << t) - 1] = 1'b1;
            end
        end
    end

    // Correction: one-hot flip of the named position when it lies inside the length
    always_comb
    begin
        found = (stage_in.syn != '0);
        bad   = found && (stage_in.syn > stage_in.len);
        flip  = '0;
        if (found && !bad)
        begin
            flip = CODE_W'(1) << (stage_in.syn - SYN_W'(1));
        end
    end

    always_comb
    begin
        if (stage_in.func == FUNC_CHECK)
        begin
            out_next.codeword      = stage_in.word ^ flip;
            out_next.syndrome      = stage_in.syn;
            out_next.error_found   = found;
            out_next.uncorrectable = bad;
        end
        else
        begin
            out_next.codeword      = stage_in.word | parity;
            out_next.syndrome      = '0;
            out_next.error_found   = 1'b0;
            out_next.uncorrectable = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = out_reg;

endmodule

// File: verif/hamming_codec_31_26_tb.sv
// Self-checking testbench for the Hamming (31,26) codec: directed table, then random phases.
module hamming_codec_31_26_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hcc_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int NUM_PHASES = 13;
    localparam int PHASE_ITEMS = 150;
    localparam int NUM_ROWS = 22;

    // One directed row; typed = 1 means the expected fields below are used as given
    typedef struct packed {
        logic [DBITS_W-1:0] dbits;
        logic               func;
        logic [CODE_W-1:0]  payload;
        logic               typed;
        logic [CODE_W-1:0]  cw;
        logic [SYN_W-1:0]   syn;
        logic               found;
        logic               bad;
    } stim_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    hcc_in_t                 in_data;
    logic                    out_valid;
    logic                    out_stall;
    hcc_out_t                out_data;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    hcc_out_t                results_due[$];
    logic [DBITS_W-1:0]      cur_dbits = DATA_BITS_RESET;
    int                      fail_count = 0;
    int                      send_gap_pct = 8;
    int                      stall_pct = 78;

    stim_row_t dir_rows [NUM_ROWS] = '{
        // reset length 7: extremes, clean words, single errors, junk above the length
        '{5'd4,  FUNC_ENCODE, 31'h0,        1'b1, 31'h0,        5'd0,  1'b0, 1'b0},
        '{5'd4,  FUNC_ENCODE, 31'h7FFFFFFF, 1'b1, 31'h7F,       5'd0,  1'b0, 1'b0},
        '{5'd4,  FUNC_CHECK,  31'h0,        1'b1, 31'h0,        5'd0,  1'b0, 1'b0},
        '{5'd4,  FUNC_CHECK,  31'h7F,       1'b1, 31'h7F,       5'd0,  1'b0, 1'b0},
        '{5'd4,  FUNC_CHECK,  31'h7FFFFFFF, 1'b1, 31'h7F,       5'd0,  1'b0, 1'b0},
        '{5'd4,  FUNC_CHECK,  31'h40,       1'b1, 31'h0,        5'd7,  1'b1, 1'b0},
        '{5'd4,  FUNC_CHECK,  31'h1,        1'b1, 31'h0,        5'd1,  1'b1, 1'b0},
        '{5'd4,  FUNC_ENCODE, 31'h5,        1'b0, 31'h0,        5'd0,  1'b0, 1'b0},
        // zero data bits behaves as one data bit
        '{5'd0,  FUNC_ENCODE, 31'h7FFFFFFF, 1'b1, 31'h7,        5'd0,  1'b0, 1'b0},
        '{5'd0,  FUNC_CHECK,  31'h4,        1'b1, 31'h0,        5'd3,  1'b1, 1'b0},
        '{5'd1,  FUNC_CHECK,  31'h3,        1'b1, 31'h7,        5'd3,  1'b1, 1'b0},
        // syndrome past the length: flagged, nothing flipped
        '{5'd2,  FUNC_CHECK,  31'hA,        1'b1, 31'hA,        5'd6,  1'b1, 1'b1},
        '{5'd2,  FUNC_ENCODE, 31'h3,        1'b0, 31'h0,        5'd0,  1'b0, 1'b0},
        // full length 31
        '{5'd26, FUNC_ENCODE, 31'h7FFFFFFF, 1'b1, 31'h7FFFFFFF, 5'd0,  1'b0, 1'b0},
        '{5'd26, FUNC_CHECK,  31'h7FFFFFFF, 1'b1, 31'h7FFFFFFF, 5'd0,  1'b0, 1'b0},
        '{5'd26, FUNC_CHECK,  31'h40000000, 1'b1, 31'h0,        5'd31, 1'b1, 1'b0},
        // data bits above 26 clamp to 26; then settings at the length-band edges
        '{5'd31, FUNC_ENCODE, 31'h2AAAAAAA, 1'b0, 31'h0,        5'd0,  1'b0, 1'b0},
        '{5'd27, FUNC_CHECK,  31'h12345678, 1'b0, 31'h0,        5'd0,  1'b0, 1'b0},
        '{5'd11, FUNC_CHECK,  31'h4000,     1'b0, 31'h0,        5'd0,  1'b0, 1'b0},
        '{5'd12, FUNC_CHECK,  31'h8002,     1'b1, 31'h8002,     5'd18, 1'b1, 1'b1},
        '{5'd5,  FUNC_ENCODE, 31'h1F,       1'b0, 31'h0,        5'd0,  1'b0, 1'b0},
        '{5'd4,  FUNC_CHECK,  31'h1E,       1'b0, 31'h0,        5'd0,  1'b0, 1'b0}
    };

    logic [DBITS_W-1:0] phase_bits [12] = '{
        5'd4, 5'd0, 5'd1, 5'd2, 5'd3, 5'd5, 5'd11, 5'd12, 5'd25, 5'd26, 5'd27, 5'd31
    };

    hamming_codec_31_26 u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Codeword length for a data-bit setting, with the zero and above-26 clamps
    function automatic int unsigned code_len(input logic [DBITS_W-1:0] db);
        int unsigned d;
        d = db;
        if (d == 0)
        begin
            d = 1;
        end
        if (d > 26)
        begin
            d = 26;
        end
        if (d == 1)
        begin
            return 3;
        end
        if (d < 5)
        begin
            return d + 3;
        end
        if (d < 12)
        begin
            return d + 4;
        end
        return d + 5;
    endfunction

    function automatic logic [CODE_W-1:0] len_keep(input int unsigned len);
        return (len >= 31) ? '1 : CODE_W'((32'd1 << len) - 1);
    endfunction

    // XOR of the indices of set positions 1..len
    function automatic logic [SYN_W-1:0] xor_positions(input logic [CODE_W-1:0] w,
                                                        input int unsigned len);
        logic [SYN_W-1:0] s;
        s = '0;
        for (int p = 1; p <= len; p++)
        begin
            if (w[p-1])
            begin
                s = s ^ SYN_W'(p);
            end
        end
        return s;
    endfunction

    // Expected codec output for one transfer under a given data-bit setting
    function automatic hcc_out_t hamming_predict(input hcc_in_t item,
                                                 input logic [DBITS_W-1:0] db);
        int unsigned len;
        int unsigned k;
        logic [CODE_W-1:0] word;
        logic [CODE_W-1:0] keep;
        logic [SYN_W-1:0] syn;
        hcc_out_t res;
        len = code_len(db);
        keep = len_keep(len);
        word = '0;
        res = '0;
        k = 0;
        if (item.func == FUNC_ENCODE)
        begin
            // data into non-power-of-two positions, then even parity
            for (int p = 1; p <= len; p++)
            begin
                if ((p & (p - 1)) != 0)
                begin
                    word[p-1] = item.payload[k];
                    k++;
                end
            end
            syn = xor_positions(word, len);
            for (int t = 0; t < SYN_W; t++)
            begin
                if ((1 << t) <= len && syn[t])
                begin
                    word[(1 << t) - 1] = 1'b1;
                end
            end
        end
        else
        begin
            word = item.payload & keep;
            syn = xor_positions(word, len);
            res.syndrome = syn;
            if (syn != 0)
            begin
                res.error_found = 1'b1;
                if (syn > len)
                begin
                    res.uncorrectable = 1'b1;
                end
                else
                begin
                    word[syn-1] = ~word[syn-1];
                end
            end
        end
        res.codeword = word & keep;
        return res;
    endfunction

    // Present one transfer after an optional gap, then log its expected result
    task automatic transfer_word(input hcc_in_t item, input hcc_out_t want);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do
            @(posedge clk);
        while (in_stall);
        results_due.push_back(want);
    endtask

    // Stop sending and wait for every outstanding result, plus pipeline slack
    task automatic drain_codec();
        in_valid <= 1'b0;
        while (results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // APB write of data_bits: setup cycle, then access cycle
    task automatic write_data_bits(input logic [DBITS_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'({REG_DATA_BITS, 2'b00});
        pwdata <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_dbits = value;
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver stall pattern
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Compare each output transfer with the oldest expected result
    always @(posedge clk)
    begin : check_results
        hcc_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (results_due.size() == 0)
            begin
                $error("unexpected transfer: codeword %h", out_data.codeword);
                fail_count++;
            end
            else
            begin
                want = results_due.pop_front();
                if (out_data.codeword !== want.codeword)
                begin
                    $error("codeword: expected %h, got %h", want.codeword, out_data.codeword);
                    fail_count++;
                end
                if (out_data.syndrome !== want.syndrome)
                begin
                    $error("syndrome: expected %0d, got %0d", want.syndrome,
                           out_data.syndrome);
                    fail_count++;
                end
                if (out_data.error_found !== want.error_found)
                begin
                    $error("error_found: expected %b, got %b", want.error_found,
                           out_data.error_found);
                    fail_count++;
                end
                if (out_data.uncorrectable !== want.uncorrectable)
                begin
                    $error("uncorrectable: expected %b, got %b", want.uncorrectable,
                           out_data.uncorrectable);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too many cycles without any transfer ends the run
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("[hamming_codec_31_26] ERROR");
        $finish;
    end

    // Stimulus
    initial
    begin : stimulus
        hcc_in_t item;
        hcc_out_t want;
        logic [DBITS_W-1:0] db;
        logic [CODE_W-1:0] word;
        int unsigned len;
        int unsigned pick;
        int unsigned pos;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        out_stall <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].dbits != cur_dbits)
            begin
                drain_codec();
                write_data_bits(dir_rows[i].dbits);
            end
            item.func = dir_rows[i].func;
            item.payload = dir_rows[i].payload;
            if (dir_rows[i].typed)
            begin
                want.codeword = dir_rows[i].cw;
                want.syndrome = dir_rows[i].syn;
                want.error_found = dir_rows[i].found;
                want.uncorrectable = dir_rows[i].bad;
            end
            else
            begin
                want = hamming_predict(item, cur_dbits);
            end
            transfer_word(item, want);
        end

        // Random phases, one data-bit setting each
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain_codec();
            if (ph < 5)
            begin
                send_gap_pct = 8;
                stall_pct = 78;
            end
            else if (ph < 9)
            begin
                send_gap_pct = 78;
                stall_pct = 8;
            end
            else
            begin
                send_gap_pct = 0;
                stall_pct = 0;
            end
            if (ph < 12)
            begin
                db = phase_bits[ph];
            end
            else
            begin
                db = DBITS_W'($urandom_range(0, 31));
            end
            write_data_bits(db);
            len = code_len(cur_dbits);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                begin
                    item.func = FUNC_ENCODE;
                    item.payload = CODE_W'($urandom);
                end
                else
                begin
                    // valid codewords, many with one flip, some with two, some noise
                    item.func = FUNC_ENCODE;
                    item.payload = CODE_W'($urandom);
                    want = hamming_predict(item, cur_dbits);
                    word = want.codeword;
                    if (pick >= 55 && pick < 85)
                    begin
                        pos = $urandom_range(0, len - 1);
                        word[pos] = ~word[pos];
                    end
                    else if (pick >= 85 && pick < 93)
                    begin
                        pos = $urandom_range(0, len - 1);
                        word[pos] = ~word[pos];
                        pos = $urandom_range(0, len - 1);
                        word[pos] = ~word[pos];
                    end
                    else if (pick >= 93)
                    begin
                        word = CODE_W'($urandom);
                    end
                    if ($urandom_range(0, 9) == 0)
                    begin
                        word = word | (CODE_W'($urandom) & ~len_keep(len));
                    end
                    item.func = FUNC_CHECK;
                    item.payload = word;
                end
                transfer_word(item, hamming_predict(item, cur_dbits));
            end
        end

        // Drain and finish
        in_valid <= 1'b0;
        while (results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("[hamming_codec_31_26] OK");
        end
        else
        begin
            $display("[hamming_codec_31_26] ERROR");
        end
        $finish;
    end

endmodule

// File: hamming_codec_31_26.f
sv/hcc_pkg.sv
sv/hcc_regs.sv
sv/hcc_stage_in.sv
sv/hcc_syndrome.sv
sv/hcc_correct.sv
sv/hamming_codec_31_26.sv
verif/hamming_codec_31_26_tb.sv
